// ----- rtl/optical_flow_dead_reckoning_unit_assert.svh -----
// assertion macros for the optical flow dead reckoning unit
// used by the top level only, no other dependencies
`ifndef OPTICAL_FLOW_DEAD_RECKONING_UNIT_ASSERT_SVH
`define OPTICAL_FLOW_DEAD_RECKONING_UNIT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define OFDR_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define OFDR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/ofdr_pkg.sv -----
// shared types and constants for the optical flow dead reckoning unit
// no dependencies
package ofdr_pkg;

  localparam int CordicIter = 16;
  localparam int AngW = 32;
  localparam int CordW = 40;
  localparam int IterW = $clog2(CordicIter + 1);
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_LEVER_ARM = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CM_PER_COUNT = 1'b1;

  localparam logic [11:0] LeverArmReset = 12'd640;
  localparam logic [15:0] CmPerCountReset = 16'd666;
  localparam logic signed [CordW-1:0] CordicGain = 40'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_ROT,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic vector_mode;
  } cordic_ctl_t;

  // binary angle arctangent table, 2^32 = 2 pi
  function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 32'd536870912;
      5'd1: atan_entry = 32'd316933406;
      5'd2: atan_entry = 32'd167458907;
      5'd3: atan_entry = 32'd85004756;
      5'd4: atan_entry = 32'd42667331;
      5'd5: atan_entry = 32'd21354465;
      5'd6: atan_entry = 32'd10679838;
      5'd7: atan_entry = 32'd5340245;
      5'd8: atan_entry = 32'd2670163;
      5'd9: atan_entry = 32'd1335087;
      5'd10: atan_entry = 32'd667544;
      5'd11: atan_entry = 32'd333772;
      5'd12: atan_entry = 32'd166886;
      5'd13: atan_entry = 32'd83443;
      5'd14: atan_entry = 32'd41722;
      5'd15: atan_entry = 32'd20861;
      5'd16: atan_entry = 32'd10430;
      5'd17: atan_entry = 32'd5215;
      5'd18: atan_entry = 32'd2608;
      5'd19: atan_entry = 32'd1304;
      5'd20: atan_entry = 32'd652;
      5'd21: atan_entry = 32'd326;
      5'd22: atan_entry = 32'd163;
      5'd23: atan_entry = 32'd81;
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

// ----- rtl/ofdr_if.sv -----
// valid/ready channel interfaces for the dead reckoning unit
// no dependencies
interface ofdr_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [7:0] delta_lateral;
  logic signed [7:0] delta_forward;
  modport source (output valid, req_type, delta_lateral, delta_forward, input ready);
  modport sink (input valid, req_type, delta_lateral, delta_forward, output ready);
endinterface

interface ofdr_res_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [15:0] heading_out;
  modport source (output valid, x_out, y_out, heading_out, input ready);
  modport sink (input valid, x_out, y_out, heading_out, output ready);
endinterface

// ----- rtl/ofdr_cordic.sv -----
// iterative cordic, one micro-rotation per cycle, vectoring or rotation mode
// depends on ofdr_pkg
module ofdr_cordic import ofdr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cordic_ctl_t             ctl,
  input  logic signed [CordW-1:0] x_init,
  input  logic signed [CordW-1:0] y_init,
  input  logic signed [AngW-1:0]  z_init,
  output logic                    busy,
  output logic signed [CordW-1:0] x_res,
  output logic signed [CordW-1:0] y_res,
  output logic signed [AngW-1:0]  z_res
);
  logic signed [CordW-1:0] x, y, xs, ys;
  logic signed [AngW-1:0] z, ang;
  logic [IterW-1:0] iter;
  logic vec, go_pos;

  // shifted terms and direction for this step
  always_comb begin
    xs = x >>> iter;
    ys = y >>> iter;
    ang = signed'(atan_entry(5'(iter)));
    go_pos = vec ? (y > 0) : (z >= 0);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == IterW'(CordicIter - 1)) busy <= 1'b0;
      iter <= iter + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x <= x_init;
      y <= y_init;
      z <= z_init;
      vec <= ctl.vector_mode;
    end else if (busy) begin
      if (go_pos == vec) begin
        x <= x + ys;
        y <= y - xs;
      end else begin
        x <= x - ys;
        y <= y + xs;
      end
      z <= go_pos ? z - (vec ? -ang : ang) : z + (vec ? -ang : ang);
    end
  end

  assign x_res = x;
  assign y_res = y;
  assign z_res = z;
endmodule

// ----- rtl/optical_flow_dead_reckoning_unit.sv -----
// Dead reckoning unit: each motion transaction runs a vectoring CORDIC pass
// for the turn angle, a rotation CORDIC pass for sin/cos and a shift-add
// multiplier (one bit of cm_per_count a cycle) for both position steps,
// stepping through ST_VEC, ST_ROT, ST_MUL and ST_DONE in that order; a clear
// transaction goes from idle straight to the done state. The next
// transaction is accepted only once the state is back in idle. One item is in
// flight at a time; the result register frees the input side, and a finished
// item waits in the done state while an earlier result is still unread.
// depends on ofdr_pkg, ofdr_if, ofdr_cordic, optical_flow_dead_reckoning_unit_assert.svh
`include "optical_flow_dead_reckoning_unit_assert.svh"
module optical_flow_dead_reckoning_unit import ofdr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ofdr_req_if.sink            req,
  ofdr_res_if.source          res
);
  state_t state, state_next;
  logic [11:0] lever_arm;
  logic [15:0] cm_per_count;
  logic [15:0] heading;
  logic [15:0] head_r;
  logic [31:0] x_acc, y_acc;
  logic signed [7:0] lat, fwd;
  logic clear_req;
  cordic_ctl_t cctl;
  logic cbusy, cbusy_d;
  logic signed [CordW-1:0] cx, cy, cx_init, cy_init;
  logic signed [AngW-1:0] cz, cz_init;
  logic [4:0] mcnt;
  logic signed [63:0] sx, sy, px, py;
  logic [15:0] mshift;
  logic out_valid;
  logic [31:0] turn;
  logic [15:0] head_new;
  logic [31:0] t_ang, t_fl;
  logic flip;
  logic flip_r;
  logic signed [CordW-1:0] s_sel, c_sel;

  assign req.ready = (state == ST_IDLE);
  wire acc_in = req.valid && req.ready;
  wire cdone = cbusy_d && !cbusy;
  wire done_go = (state == ST_DONE) && (!out_valid || res.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lever_arm <= LeverArmReset;
      cm_per_count <= CmPerCountReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVER_ARM: lever_arm <= cfg_data[11:0];
        CFG_CM_PER_COUNT: cm_per_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc_in) state_next = req.req_type ? ST_DONE : ST_VEC;
      ST_VEC: if (cdone) state_next = ST_ROT;
      ST_ROT: if (cdone) state_next = ST_MUL;
      ST_MUL: if (mcnt == 5'd15) state_next = ST_DONE;
      ST_DONE: if (done_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // rounded turn and new heading, rotation start angle with half-turn fold
  always_comb begin
    turn = 32'(cz + 32'sd32768);
    head_new = (lat == 8'sd0) ? heading : heading - turn[31:16];
    t_ang = {head_new, 16'h0};
    flip = (t_ang >= 32'h4000_0000) && (t_ang < 32'hC000_0000);
    t_fl = flip ? t_ang + 32'h8000_0000 : t_ang;
  end

  // cordic start controls
  always_comb begin
    cctl.start = 1'b0;
    cctl.vector_mode = 1'b1;
    cx_init = CordW'(signed'({1'b0, lever_arm})) <<< 16;
    cy_init = CordW'(req.delta_lateral) <<< 16;
    cz_init = '0;
    case (state)
      ST_IDLE: cctl.start = acc_in && !req.req_type;
      ST_VEC: begin
        cctl.start = cdone;
        cctl.vector_mode = 1'b0;
        cx_init = CordicGain;
        cy_init = '0;
        cz_init = signed'(t_fl);
      end
      default: ;
    endcase
  end

  ofdr_cordic u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl), .x_init(cx_init), .y_init(cy_init),
    .z_init(cz_init), .busy(cbusy), .x_res(cx), .y_res(cy), .z_res(cz)
  );

  always_ff @(posedge clk) begin
    if (rst) cbusy_d <= 1'b0;
    else cbusy_d <= cbusy || cctl.start;
  end

  assign s_sel = flip_r ? -cy : cy;
  assign c_sel = flip_r ? -cx : cx;

  // state, accumulators and bit-serial multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      heading <= '0;
      x_acc <= '0;
      y_acc <= '0;
      out_valid <= 1'b0;
      mcnt <= '0;
    end else begin
      state <= state_next;
      if (done_go) out_valid <= 1'b1;
      else if (res.valid && res.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (acc_in) begin
          lat <= req.delta_lateral;
          fwd <= req.delta_forward;
          clear_req <= req.req_type;
        end
        ST_VEC: if (cdone) begin
          head_r <= head_new;
          flip_r <= flip;
        end
        ST_ROT: if (cdone) begin
          sx <= 64'(s_sel) * 64'(fwd);
          sy <= 64'(c_sel) * 64'(fwd);
          px <= 64'sd536870912;
          py <= 64'sd536870912;
          mshift <= cm_per_count;
          mcnt <= '0;
        end
        ST_MUL: begin
          if (mshift[0]) begin
            px <= px + sx;
            py <= py + sy;
          end
          sx <= sx <<< 1;
          sy <= sy <<< 1;
          mshift <= mshift >> 1;
          mcnt <= mcnt + 1'b1;
        end
        ST_DONE: if (done_go) begin
          if (clear_req) begin
            heading <= '0;
            x_acc <= '0;
            y_acc <= '0;
          end else begin
            heading <= head_r;
            x_acc <= x_acc + 32'(px >>> 30);
            y_acc <= y_acc + 32'(py >>> 30);
          end
        end
        default: ;
      endcase
    end
  end

  assign res.valid = out_valid;
  assign res.x_out = x_acc;
  assign res.y_out = y_acc;
  assign res.heading_out = heading;

  `OFDR_ASSERT_IMPL(a_no_accept_busy, state != ST_IDLE, !req.ready)
  `OFDR_ASSERT_NEXT(a_done_valid, state == ST_DONE, res.valid)
  `OFDR_ASSERT_NEXT(a_valid_hold, res.valid && !res.ready, res.valid)
  `OFDR_ASSERT_NEXT(a_payload_hold, res.valid && !res.ready, $stable(res.x_out) && $stable(res.y_out) && $stable(res.heading_out))
endmodule
